// ----- sv/cdc_pkg.sv -----
package cdc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [YearW-1:0]  MinYear    = 14'd1900;
  localparam logic [YearW-1:0]  MaxYearDef = 14'd9999;
  localparam logic [MonthW-1:0] FirstMonth = 4'd1;
  localparam logic [MonthW-1:0] LastMonth  = 4'd12;
  localparam logic [DayW-1:0]   FirstDay   = 5'd1;
  localparam logic [DayW-1:0]   LastDayDec = 5'd31;

  // inverse of 25 modulo 2**YearW, and the largest product of a multiple of 25
  localparam logic [YearW-1:0] Inv25    = 14'd7209;
  localparam logic [YearW-1:0] Div25Lim = 14'd655;

  typedef enum logic [2:0] {
    ActLoad      = 3'd0,
    ActNextDay   = 3'd1,
    ActNextMonth = 3'd2,
    ActNextYear  = 3'd3,
    ActPrevDay   = 3'd4,
    ActPrevMonth = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDefault = 2'd1,
    StHeld    = 2'd2
  } status_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } cmd_t;

  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/cdc_leap.sv -----
module cdc_leap
  import cdc_pkg::*;
(
  input  logic [YearW-1:0] year_i,
  output logic             leap_o
);

  logic [YearW-1:0] prod;
  logic             div25;

  assign prod   = year_i * Inv25;
  assign div25  = (prod <= Div25Lim);
  assign leap_o = (year_i[1:0] == 2'b00) && (!div25 || (year_i[3:0] == 4'b0000));

endmodule

// ----- sv/cdc_step.sv -----
module cdc_step
  import cdc_pkg::*;
#(
  parameter logic [YearW-1:0] MaxYear = MaxYearDef
) (
  input  date_t       date_i,
  input  cmd_t        cmd_i,
  output date_t       date_o,
  output logic [1:0]  status_o
);

  logic             leap_cur;
  logic             leap_ld;
  logic [YearW-1:0] ld_year;
  logic             ld_held;
  logic             ld_year_repl;
  logic [DayW-1:0]  cur_len;
  logic [DayW-1:0]  prev_len;
  logic [MonthW-1:0] prev_month;

  always_comb begin
    ld_held      = 1'b0;
    ld_year_repl = 1'b0;
    ld_year      = cmd_i.year;
    if (cmd_i.year < MinYear) begin
      ld_year      = MinYear;
      ld_year_repl = 1'b1;
    end else if (cmd_i.year > MaxYear) begin
      ld_year = MaxYear;
      ld_held = 1'b1;
    end
  end

  cdc_leap u_leap_cur (
    .year_i (date_i.year),
    .leap_o (leap_cur)
  );

  cdc_leap u_leap_ld (
    .year_i (ld_year),
    .leap_o (leap_ld)
  );

  assign prev_month = date_i.month - 4'd1;
  assign cur_len    = month_len(date_i.month, leap_cur);
  assign prev_len   = month_len(prev_month, leap_cur);

  always_comb begin
    logic              repl;
    logic [MonthW-1:0] nm;
    logic [DayW-1:0]   nd;
    repl     = ld_year_repl;
    nm       = cmd_i.month;
    nd       = cmd_i.day;
    date_o   = date_i;
    status_o = StOk;
    case (action_e'(cmd_i.action))
      ActLoad: begin
        if (nm < FirstMonth || nm > LastMonth) begin
          nm   = FirstMonth;
          repl = 1'b1;
        end
        if (nd < FirstDay || nd > month_len(nm, leap_ld)) begin
          nd   = FirstDay;
          repl = 1'b1;
        end
        date_o.year  = ld_year;
        date_o.month = nm;
        date_o.day   = nd;
        status_o     = ld_held ? StHeld : (repl ? StDefault : StOk);
      end
      ActNextDay: begin
        if (date_i.day < cur_len) begin
          date_o.day = date_i.day + 5'd1;
        end else if (date_i.month < LastMonth) begin
          date_o.day   = FirstDay;
          date_o.month = date_i.month + 4'd1;
        end else if (date_i.year < MaxYear) begin
          date_o.day   = FirstDay;
          date_o.month = FirstMonth;
          date_o.year  = date_i.year + 14'd1;
        end else begin
          status_o = StHeld;
        end
      end
      ActNextMonth: begin
        if (date_i.month < LastMonth) begin
          date_o.month = date_i.month + 4'd1;
        end else if (date_i.year < MaxYear) begin
          date_o.month = FirstMonth;
          date_o.year  = date_i.year + 14'd1;
        end else begin
          status_o = StHeld;
        end
      end
      ActNextYear: begin
        if (date_i.year < MaxYear) begin
          date_o.year = date_i.year + 14'd1;
        end else begin
          status_o = StHeld;
        end
      end
      ActPrevDay: begin
        if (date_i.day > FirstDay) begin
          date_o.day = date_i.day - 5'd1;
        end else if (date_i.month > FirstMonth) begin
          date_o.month = prev_month;
          date_o.day   = prev_len;
        end else if (date_i.year > MinYear) begin
          date_o.year  = date_i.year - 14'd1;
          date_o.month = LastMonth;
          date_o.day   = LastDayDec;
        end else begin
          status_o = StHeld;
        end
      end
      ActPrevMonth: begin
        if (date_i.month > FirstMonth) begin
          date_o.month = prev_month;
        end else if (date_i.year > MinYear) begin
          date_o.month = LastMonth;
          date_o.year  = date_i.year - 14'd1;
        end else begin
          status_o = StHeld;
        end
      end
      default: begin
        date_o = date_i;
      end
    endcase
  end

endmodule

// ----- sv/calendar_date_counter.sv -----
// Channel | Handshake              | Payload
// in      | in_valid_i, in_stall_o | action_i, new_year_i, new_month_i, new_day_i
// out     | out_valid_o, out_stall_i | cur_year_o, cur_month_o, cur_day_o, leap_flag_o, status_o
//
// One action per cycle sustained while out_stall_i is low; out_valid_o rises once a transfer in
// has passed the input register and then the date update into the state and result registers.
// Each leap test, for the update and for leap_flag_o, is one 14-bit constant multiply.
// Reset sets the date to 1900-01-01 and empties both registers.
// A stalled output holds its result; the input stage takes one more action, then stalls.
module calendar_date_counter
  import cdc_pkg::*;
#(
  parameter logic [YearW-1:0] MaxYear = MaxYearDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        action_i,
  input  logic [YearW-1:0]  new_year_i,
  input  logic [MonthW-1:0] new_month_i,
  input  logic [DayW-1:0]   new_day_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [YearW-1:0]  cur_year_o,
  output logic [MonthW-1:0] cur_month_o,
  output logic [DayW-1:0]   cur_day_o,
  output logic              leap_flag_o,
  output logic [1:0]        status_o
);

  logic       cmd_valid_q;
  cmd_t       cmd_q;
  date_t      date_q;
  date_t      date_d;
  logic [1:0] status_d;
  logic       out_valid_q;
  date_t      res_q;
  logic [1:0] status_q;
  logic       advance;
  logic       accept;

  assign advance    = cmd_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = cmd_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (accept) begin
      cmd_valid_q <= 1'b1;
    end else if (advance) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= '{action: action_i, year: new_year_i, month: new_month_i, day: new_day_i};
    end
  end

  cdc_step #(
    .MaxYear (MaxYear)
  ) u_step (
    .date_i   (date_q),
    .cmd_i    (cmd_q),
    .date_o   (date_d),
    .status_o (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q      <= '{year: MinYear, month: FirstMonth, day: FirstDay};
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        date_q      <= date_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q    <= date_d;
      status_q <= status_d;
    end
  end

  cdc_leap u_leap_out (
    .year_i (res_q.year),
    .leap_o (leap_flag_o)
  );

  assign out_valid_o = out_valid_q;
  assign cur_year_o  = res_q.year;
  assign cur_month_o = res_q.month;
  assign cur_day_o   = res_q.day;
  assign status_o    = status_q;

endmodule
